@@ rtl/core/sbp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sbp_pkg
// Shared types and constants of the stream byte patcher.
// ----------------------------------------------------------------------------
package sbp_pkg;

	localparam int unsigned MaxEntriesDefault = 1024;
	localparam int unsigned PatchLen = 5;
	localparam logic [7:0] UnitBytes = 8'hC0;

	typedef enum logic [1:0] {
		ACT_CLEAR  = 2'd0,
		ACT_LOAD   = 2'd1,
		ACT_SEEK   = 2'd2,
		ACT_STREAM = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		CFG_KEY_HIGH  = 2'd0,
		CFG_KEY_LOW   = 2'd1,
		CFG_MASK_BITS = 2'd2
	} cfg_index_t;

	typedef struct packed {
		logic load;
		logic clear;
		logic seek;
		logic capture;
		logic rd;
		logic calc;
		logic judge;
		logic advance;
		logic emit;
		logic emit_byte;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic more;
		logic skip;
		logic out_busy;
	} stat_t;

endpackage
`default_nettype wire

@@ rtl/core/stream_byte_patcher_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// stream_byte_patcher_top
// Patch table with key decryption and a patching byte stream.
// ----------------------------------------------------------------------------
// Clear, load and seek are taken in the idle state. A stream byte walks the
// entries from the pointer: an entry is read from the entry memory (READ), its
// two patch locations are formed (CALC) and compared with the position (JUDGE);
// an entry passed over goes through WAIT to the next, and with no entry left
// the byte goes out unpatched from WAIT. A result still waiting on m_tready
// holds off the next transfer.
module stream_byte_patcher_top #(
	parameter int unsigned MAX_ENTRIES = sbp_pkg::MaxEntriesDefault
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [63:0]  cfg_data,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// action
	input  wire logic [1:0]   s_tuser,
	// base_index, entry_flag_byte, first_adjust, second_adjust,
	// first_byte_offset, second_byte_offset, first_patch, second_patch,
	// seek_position, data_byte
	input  wire logic [215:0] s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// out_byte, was_patched, status, zero fill
	output logic [15:0]       m_tdata
);
	sbp_pkg::cmd_t  cmd;
	sbp_pkg::stat_t stat;

	sbp_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.action(s_tuser), .stat(stat), .cmd(cmd)
	);

	sbp_datapath #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.base_index(s_tdata[31:0]), .entry_flag_byte(s_tdata[39:32]),
		.first_adjust(s_tdata[51:40]), .second_adjust(s_tdata[63:52]),
		.first_byte_offset(s_tdata[71:64]), .second_byte_offset(s_tdata[79:72]),
		.first_patch(s_tdata[119:80]), .second_patch(s_tdata[159:120]),
		.seek_position(s_tdata[207:160]), .data_byte(s_tdata[215:208]),
		.m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready)
	);
endmodule
`default_nettype wire

@@ rtl/core/sbp_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sbp_datapath
// Entry memory, key decryption, location arithmetic and output register.
// ----------------------------------------------------------------------------
module sbp_datapath #(
	parameter int unsigned MAX_ENTRIES = sbp_pkg::MaxEntriesDefault
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire sbp_pkg::cmd_t cmd,
	output sbp_pkg::stat_t     stat,
	input  wire logic          cfg_we,
	input  wire logic [1:0]    cfg_index,
	input  wire logic [63:0]   cfg_data,
	input  wire logic [31:0]   base_index,
	input  wire logic [7:0]    entry_flag_byte,
	input  wire logic [11:0]   first_adjust,
	input  wire logic [11:0]   second_adjust,
	input  wire logic [7:0]    first_byte_offset,
	input  wire logic [7:0]    second_byte_offset,
	input  wire logic [39:0]   first_patch,
	input  wire logic [39:0]   second_patch,
	input  wire logic [47:0]   seek_position,
	input  wire logic [7:0]    data_byte,
	output logic [15:0]        m_tdata,
	output logic               m_tvalid,
	input  wire logic          m_tready
);
	localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
	localparam int unsigned EW = 32 + 24 + 16 + 40 + 40 + 1;

	logic [63:0] key_high_q, key_low_q, mask_bits_q;
	logic [EW-1:0] mem [MAX_ENTRIES];
	logic [EW-1:0] rd_q;
	logic [CW-1:0] count_q, ptr_q;
	logic [47:0] pos_q;
	logic [7:0] byte_q;
	logic [49:0] o0_q, o1_q;
	logic [7:0] obyte_q;
	logic patched_q, status_q, vld_q;
	logic [7:0] flags;
	logic act;
	logic [EW-1:0] wr_entry;
	logic [23:0] kb13;
	logic [31:0] r_base;
	logic [11:0] r_a0, r_a1;
	logic [7:0] r_f0, r_f1;
	logic [39:0] r_p0, r_p1;
	logic r_act;
	logic [33:0] u0, u1;
	logic [49:0] d0, d1;
	logic hit0, hit1;
	logic [7:0] sel_byte;
	logic [2:0] i0, i1;

	assign kb13 = key_high_q[55:32];
	assign flags = entry_flag_byte ^ key_high_q[63:56];
	always_comb begin
		case (flags[7:6])
			2'd1: act = 1'b1;
			2'd2: act = mask_bits_q[flags[5:0]];
			default: act = 1'b0;
		endcase
	end
	assign wr_entry = {base_index, first_adjust ^ kb13[23:12], second_adjust ^ kb13[11:0],
		first_byte_offset ^ key_high_q[31:24], second_byte_offset ^ key_high_q[23:16],
		first_patch ^ {key_high_q[15:0], key_low_q[63:40]},
		second_patch ^ key_low_q[39:0], act};
	assign {r_base, r_a0, r_a1, r_f0, r_f1, r_p0, r_p1, r_act} = rd_q;
	assign u0 = {2'b0, r_base} + {22'b0, r_a0};
	assign u1 = u0 + {22'b0, r_a1};

	assign d0 = {2'b0, pos_q} - o0_q;
	assign d1 = {2'b0, pos_q} - o1_q;
	assign hit1 = ({2'b0, pos_q} >= o1_q) && (d1 < 50'(sbp_pkg::PatchLen));
	assign hit0 = ({2'b0, pos_q} >= o0_q) && (d0 < 50'(sbp_pkg::PatchLen));
	assign i1 = d1[2:0];
	assign i0 = d0[2:0];
	always_comb begin
		sel_byte = byte_q;
		if (hit1) begin
			sel_byte = r_p1[8*(4-i1) +: 8];
		end else if (hit0) begin
			sel_byte = r_p0[8*(4-i0) +: 8];
		end
	end

	assign stat.full = (count_q == CW'(MAX_ENTRIES));
	assign stat.more = (ptr_q < count_q);
	assign stat.skip = !r_act || (o1_q + 50'(sbp_pkg::PatchLen) <= {2'b0, pos_q});
	assign stat.out_busy = vld_q && !m_tready;

	always_ff @(posedge clk) begin
		if (cmd.load && !stat.full) begin
			mem[count_q[AW-1:0]] <= wr_entry;
		end
		if (cmd.rd) begin
			rd_q <= mem[ptr_q[AW-1:0]];
		end
		if (cmd.calc) begin
			o0_q <= ({16'b0, u0} * 50'(sbp_pkg::UnitBytes)) + {42'b0, r_f0};
			o1_q <= ({16'b0, u1} * 50'(sbp_pkg::UnitBytes)) + {42'b0, r_f1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q <= '0;
			mask_bits_q <= '0;
			count_q <= '0;
			ptr_q <= '0;
			pos_q <= '0;
			vld_q <= 1'b0;
			byte_q <= '0;
			obyte_q <= '0;
			patched_q <= 1'b0;
			status_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					sbp_pkg::CFG_KEY_HIGH: key_high_q <= cfg_data;
					sbp_pkg::CFG_KEY_LOW: key_low_q <= cfg_data;
					sbp_pkg::CFG_MASK_BITS: mask_bits_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.clear) begin
				count_q <= '0;
				ptr_q <= '0;
			end
			if (cmd.load && !stat.full) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.seek) begin
				pos_q <= seek_position;
				ptr_q <= '0;
			end
			if (cmd.capture) begin
				byte_q <= data_byte;
			end
			if (cmd.advance) begin
				ptr_q <= ptr_q + 1'b1;
			end
			if (m_tvalid && m_tready) begin
				vld_q <= 1'b0;
			end
			if (cmd.emit) begin
				vld_q <= 1'b1;
				obyte_q <= '0;
				patched_q <= 1'b0;
				status_q <= cmd.load && stat.full;
			end
			if (cmd.emit_byte) begin
				vld_q <= 1'b1;
				status_q <= 1'b0;
				if (cmd.judge) begin
					obyte_q <= sel_byte;
					patched_q <= hit0 || hit1;
				end else begin
					obyte_q <= byte_q;
					patched_q <= 1'b0;
				end
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	assign m_tvalid = vld_q;
	assign m_tdata = {6'b0, status_q, patched_q, obyte_q};
endmodule
`default_nettype wire

@@ rtl/core/sbp_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sbp_ctrl
// Sequencer: actions, entry walk for stream bytes and output handoff.
// ----------------------------------------------------------------------------
module sbp_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           s_tvalid,
	output logic                s_tready,
	input  wire logic [1:0]     action,
	input  wire sbp_pkg::stat_t stat,
	output sbp_pkg::cmd_t       cmd
);
	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_READ  = 5'b00010,
		ST_CALC  = 5'b00100,
		ST_JUDGE = 5'b01000,
		ST_WAIT  = 5'b10000
	} state_t;

	state_t state_q, state_d;

	assign s_tready = (state_q == ST_IDLE) && !stat.out_busy;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid && s_tready) begin
					case (action)
						sbp_pkg::ACT_CLEAR: begin cmd.clear = 1'b1; cmd.emit = 1'b1; end
						sbp_pkg::ACT_LOAD: begin cmd.load = 1'b1; cmd.emit = 1'b1; end
						sbp_pkg::ACT_SEEK: begin cmd.seek = 1'b1; cmd.emit = 1'b1; end
						default: begin
							cmd.rd = 1'b1;
							cmd.capture = 1'b1;
							state_d = ST_READ;
						end
					endcase
				end
			end
			ST_READ: begin
				if (stat.more) begin
					cmd.calc = 1'b1;
					state_d = ST_CALC;
				end else begin
					state_d = ST_WAIT;
				end
			end
			ST_CALC: state_d = ST_JUDGE;
			ST_JUDGE: begin
				if (stat.skip) begin
					cmd.advance = 1'b1;
					state_d = ST_WAIT;
				end else if (!stat.out_busy) begin
					cmd.judge = 1'b1;
					cmd.emit_byte = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_WAIT: begin
				if (stat.more) begin
					cmd.rd = 1'b1;
					cmd.calc = 1'b0;
					state_d = ST_READ;
				end else if (!stat.out_busy) begin
					cmd.emit_byte = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule
`default_nettype wire
